[hw/rtl/itoa_pkg.sv]
// Shared types, constants and helpers for the signed integer to decimal text converter.
package itoa_pkg;

  // Default width of the input value that is converted
  localparam int unsigned ValueWidthDef = 64;

  // Width of one ASCII character on the output
  localparam int unsigned CharW = 7;

  // ASCII codes
  localparam logic [CharW-1:0] CharZero  = 7'h30;
  localparam logic [CharW-1:0] CharNine  = 7'h39;
  localparam logic [CharW-1:0] CharMinus = 7'h2D;

  // Decimal digits needed for any magnitude below 2^w (1233/4096 ~ log10(2))
  function automatic int unsigned digits_for(input int unsigned w);
    return ((w * 1233) >> 12) + 1;
  endfunction

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // take an input beat, start conversion
    logic conv_step;  // one shift-and-add-3 step
    logic skip_digit; // drop a leading zero digit
    logic out_sign;   // load '-' into the output register
    logic out_digit;  // load the top digit into the output register
  } itoa_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic conv_last;  // this conversion step is the final one
    logic top_zero;   // most significant remaining digit is zero
    logic rem_one;    // exactly one digit remains
    logic neg;        // current value is negative
    logic out_free;   // output register can take a beat this cycle
  } itoa_status_t;

endpackage

[hw/rtl/itoa_dp.sv]
// Datapath: magnitude, binary-to-BCD shift register, digit counters, output register.
module itoa_dp import itoa_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic signed [63:0]  in_value_i,
  input  itoa_cmd_t           cmd_i,
  output itoa_status_t        status_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [CharW-1:0]    out_character_o,
  output logic                out_last_o
);

  localparam int unsigned Digits = digits_for(VALUE_WIDTH);
  localparam int unsigned BcdW   = Digits * 4;
  localparam int unsigned CntW   = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned RemW   = $clog2(Digits + 1);

  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic                   neg_q, neg_d;
  logic [BcdW-1:0]        bcd_q, bcd_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [RemW-1:0]        rem_q, rem_d;
  logic                   out_valid_q, out_valid_d;
  logic [CharW-1:0]       char_q, char_d;
  logic                   last_q, last_d;

  logic [VALUE_WIDTH-1:0] in_v;
  logic [BcdW-1:0]        bcd_adj;
  logic [3:0]             top_digit;
  logic                   out_free;

  // Low bits of the input, read as two's complement
  assign in_v = in_value_i[VALUE_WIDTH-1:0];

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < Digits; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
                                                    : bcd_q[i*4 +: 4];
    end
  end

  assign top_digit = bcd_q[BcdW-1 -: 4];
  assign out_free  = !out_valid_q || !out_stall_i;

  // Next-state logic
  always_comb begin
    mag_d       = mag_q;
    neg_d       = neg_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    last_d      = last_q;

    if (cmd_i.load) begin
      neg_d = in_v[VALUE_WIDTH-1];
      mag_d = in_v[VALUE_WIDTH-1] ? (~in_v + VALUE_WIDTH'(1)) : in_v;
      bcd_d = '0;
      cnt_d = CntW'(VALUE_WIDTH);
      rem_d = RemW'(Digits);
    end
    if (cmd_i.conv_step) begin
      bcd_d = {bcd_adj[BcdW-2:0], mag_q[VALUE_WIDTH-1]};
      mag_d = {mag_q[VALUE_WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
    end
    if (cmd_i.skip_digit || cmd_i.out_digit) begin
      bcd_d = {bcd_q[BcdW-5:0], 4'd0};
      rem_d = rem_q - RemW'(1);
    end
    if (cmd_i.out_sign) begin
      out_valid_d = 1'b1;
      char_d      = CharMinus;
      last_d      = 1'b0;
    end
    if (cmd_i.out_digit) begin
      out_valid_d = 1'b1;
      char_d      = CharZero + {3'b000, top_digit};
      last_d      = (rem_q == RemW'(1));
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q       <= '0;
      neg_q       <= 1'b0;
      cnt_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mag_q       <= mag_d;
      neg_q       <= neg_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign status_o.conv_last = (cnt_q == CntW'(1));
  assign status_o.top_zero  = (top_digit == 4'd0);
  assign status_o.rem_one   = (rem_q == RemW'(1));
  assign status_o.neg       = neg_q;
  assign status_o.out_free  = out_free;

  assign out_valid_o     = out_valid_q;
  assign out_character_o = char_q;
  assign out_last_o      = last_q;

endmodule

[hw/rtl/itoa_ctrl.sv]
// Controller: sequences conversion, leading-zero skip and character output.
module itoa_ctrl import itoa_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  itoa_status_t status_i,
  output itoa_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StSkip,
    StSign,
    StEmit
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.conv_step = 1'b1;
        if (status_i.conv_last) begin
          state_d = StSkip;
        end
      end
      StSkip: begin
        if (status_i.top_zero && !status_i.rem_one) begin
          cmd_o.skip_digit = 1'b1;
        end else if (status_i.neg) begin
          state_d = StSign;
        end else begin
          state_d = StEmit;
        end
      end
      StSign: begin
        if (status_i.out_free) begin
          cmd_o.out_sign = 1'b1;
          state_d        = StEmit;
        end
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.out_digit = 1'b1;
          if (status_i.rem_one) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

[hw/rtl/signed_int_to_decimal_ascii.sv]
// Top level: signed integer to decimal ASCII text, one character per output beat.
// Steps: a load, VALUE_WIDTH shift-and-add-3 steps, one step per leading zero digit
// dropped and one decision step, then an optional minus sign and the digits, one
// character per cycle while the output does not stall. One value at a time: the input
// is blocked until the last digit is loaded into the output register. Reset: async,
// active low; controller idle, output empty.
module signed_int_to_decimal_ascii import itoa_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [63:0] in_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CharW-1:0]   out_character_o,
  output logic               out_last_o
);

  itoa_cmd_t    cmd;
  itoa_status_t status;

  itoa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  itoa_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_value_i      (in_value_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .out_character_o (out_character_o),
    .out_last_o      (out_last_o)
  );

  // A value in work blocks the input on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not blocked after accepted beat");

  // The sign is never the final character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_character_o == CharMinus) |-> !out_last_o)
    else $error("minus sign marked last");

  // Only digits or the minus sign appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_character_o == CharMinus) ||
                    ((out_character_o >= CharZero) && (out_character_o <= CharNine)))
    else $error("illegal output character");

endmodule

[tb/itoa_text_checker.sv]
// Checker: predicts the decimal text of each accepted value and compares output beats.
`timescale 1ns / 1ps

module itoa_text_checker import itoa_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [63:0] in_value_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [CharW-1:0]   out_character_i,
  input  logic               out_last_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int unsigned MaxDigits = 20;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic             last;
  } text_beat_t;

  text_beat_t expected_text[$];
  text_beat_t want;
  int         errors = 0;
  int         pending = 0;

  assign fail_count_o = errors;
  assign pending_o    = pending;

  // Queue the characters one value renders to: sign, then digits MSD first
  function automatic void queue_decimal_text(input logic [63:0] raw);
    logic [63:0] mask;
    logic [63:0] v;
    logic [63:0] mag;
    logic [63:0] rest;
    logic        neg;
    logic [3:0]  digits [MaxDigits];
    int          n;
    text_beat_t  beat;
    mask = (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
    v    = raw & mask;
    neg  = v[VALUE_WIDTH-1];
    mag  = neg ? ((~v + 64'd1) & mask) : v;
    n    = 0;
    rest = mag;
    if (rest == 0) begin
      digits[0] = 4'd0;
      n = 1;
    end
    // digits come out least significant first
    while (rest != 0 && n < MaxDigits) begin
      digits[n] = 4'(rest % 64'd10);
      n++;
      rest = rest / 64'd10;
    end
    if (neg) begin
      beat.character = CharMinus;
      beat.last      = 1'b0;
      expected_text.push_back(beat);
    end
    for (int i = n - 1; i >= 0; i--) begin
      beat.character = CharZero + CharW'(digits[i]);
      beat.last      = (i == 0);
      expected_text.push_back(beat);
    end
  endfunction

  // Compare output beats, then record the input beat of this edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected beat: character %h last %b", $time,
                 out_character_i, out_last_i);
        errors++;
      end else begin
        want = expected_text.pop_front();
        if (out_character_i !== want.character) begin
          $display("%0t: character mismatch: expected %h actual %h", $time,
                   want.character, out_character_i);
          errors++;
        end
        if (out_last_i !== want.last) begin
          $display("%0t: last mismatch: expected %b actual %b", $time,
                   want.last, out_last_i);
          errors++;
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_i) begin
      queue_decimal_text(in_value_i);
    end
    pending = expected_text.size();
  end

endmodule

[tb/tb_signed_int_to_decimal_ascii.sv]
// Testbench top: drives values into the converter and reports the verdict.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii import itoa_pkg::*;;

  localparam int unsigned ValueWidth   = 64;
  localparam int          ItemsPerPhase = 120;
  localparam int          CycleLimit    = 1000000;
  localparam int          DrainCycles   = 200;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [63:0] in_value;
  logic               out_valid;
  logic               out_stall;
  logic [CharW-1:0]   out_character;
  logic               out_last;
  int                 fail_count;
  int                 pending;
  int                 send_idle_pct;
  int                 recv_idle_pct;

  signed_int_to_decimal_ascii #(
    .VALUE_WIDTH(ValueWidth)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .in_value_i     (in_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_character_o(out_character),
    .out_last_o     (out_last)
  );

  itoa_text_checker #(
    .VALUE_WIDTH(ValueWidth)
  ) u_text_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_value_i     (in_value),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_character_i(out_character),
    .out_last_i     (out_last),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop on a hung run
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("tb_signed_int_to_decimal_ascii failed");
    $finish;
  end

  // Receiver backpressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // 10^k as a 64-bit value, k up to 18
  function automatic logic [63:0] pow10(input int k);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < k; i++) p = p * 64'd10;
    return p;
  endfunction

  // Random value: full range, short numbers, digit-count edges and extremes
  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    int          kind;
    kind = $urandom_range(99);
    if (kind < 40) begin
      v = {$urandom, $urandom};
    end else if (kind < 60) begin
      v = 64'($urandom_range(999));
    end else if (kind < 80) begin
      v = pow10($urandom_range(18)) + 64'($urandom_range(2)) - 64'd1;
    end else if (kind < 90) begin
      v = {$urandom, $urandom} >> $urandom_range(63);
    end else begin
      case ($urandom_range(3))
        0: v = 64'h8000_0000_0000_0000;
        1: v = 64'h7FFF_FFFF_FFFF_FFFF;
        2: v = 64'd0;
        default: v = '1;
      endcase
    end
    // random sign for the non-extreme kinds
    if (kind < 90 && $urandom_range(1)) v = ~v + 64'd1;
    return v;
  endfunction

  // Offer one value and hold it until the block accepts the beat
  task automatic send_value(input logic [63:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_value <= {$urandom, $urandom};
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
  endtask

  // Directed values: zero, one-digit edges, powers of ten, extremes
  logic [63:0] directed [] = '{
    64'd0, 64'd1, -64'sd1, 64'd9, -64'sd9, 64'd10, -64'sd10, 64'd99, 64'd100,
    64'd12345, -64'sd12345, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
    64'h8000_0000_0000_0001, 64'd1000000000000000000, -64'sd1000000000000000000,
    64'd999999999999999999, 64'h0000_0001_0000_0000, 64'hFFFF_FFFF_0000_0000,
    64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA
  };

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_value      = '0;
    send_idle_pct = 35;
    recv_idle_pct = 78;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) send_value(directed[i]);

    // receiver-heavy idling, then sender-heavy, then none
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 35; recv_idle_pct = 78; end
        1: begin send_idle_pct = 78; recv_idle_pct = 35; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      repeat (ItemsPerPhase) send_value(pick_value());
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // drain outstanding text, then watch for stray beats
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("tb_signed_int_to_decimal_ascii passed");
    end else begin
      $display("tb_signed_int_to_decimal_ascii failed");
    end
    $finish;
  end

endmodule
